[hw/rtl/adwam_pkg.sv]
// Package for the audio dB window-average level meter.
// Holds widths, arithmetic constants and register indexes; no dependencies.
package adwam_pkg;

	// Window counter width; sets the longest usable window (2^WINDOW_BITS - 1).
	localparam int WINDOW_BITS = 16;

	localparam int SAMPLE_W = 32;
	localparam int LEVEL_W  = 16;                        // Q8.8 level magnitude
	localparam int SUM_W    = WINDOW_BITS + LEVEL_W;     // window sum of levels
	localparam int QUOT_W   = SUM_W + 1;                 // quotient of the mean division
	localparam int MUL_A_W  = (SUM_W > 32) ? SUM_W : 32; // shared multiplier, A side
	localparam int MUL_B_W  = 32;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int LEN_CMP_W = (WINDOW_BITS > 16) ? WINDOW_BITS : 16;
	localparam int ITER_W   = $clog2(QUOT_W);
	localparam int EMIT_W   = 16;
	localparam int LOG_FRAC = 16;                        // fraction bits of log2
	localparam int NORM_STEPS = 5;                       // 16, 8, 4, 2, 1 bit shifts

	localparam logic [WINDOW_BITS-1:0] CNT_MAX = {WINDOW_BITS{1'b1}};

	localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR = 16'd35840;   // 140 dB in Q8.8
	localparam logic [MUL_B_W-1:0]  DB_PER_LOG2 = 32'd394566;  // 20*log10(2) in Q16
	localparam logic [MUL_B_W-1:0]  INV_SCALE   = 32'd786434;  // 1/1.33333 in Q20

	// Sample format codes
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S32 = 2'd2;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	localparam logic [1:0]  RST_FORMAT = FMT_S16;
	localparam logic [15:0] RST_LENGTH = 16'd1600;
	localparam logic [15:0] RST_LIMIT  = 16'd65535;

endpackage

[hw/rtl/audio_db_window_average_meter.sv]
// Top level of the audio dB window-average level meter: sequencer, shared
// multiplier, restoring divider and APB register file. Depends on adwam_pkg.
//
// One audio sample enters per item on the s_ stream and is turned into a
// Q8.8 dBFS level (full scale 255 for u8 without offset removal, 32767 for
// s16, 2147483647 for s32, floored at -140 dB). Levels are summed over
// window_length samples; at each window end the mean divided by 1.33333 is
// sent as one item on the m_ stream, until window_limit results are out,
// after which samples are taken and dropped. A new sample is taken only after
// the previous one is done: acceptance, 16 squaring steps for log2 of the
// full scale, 5 normalizing shift steps and 16 squaring steps for log2 of the
// magnitude, a dB scaling step and an accumulate step. All squaring and both
// constant scalings share one 32x32 multiplier. Silent and full-scale samples
// skip the log and go straight to the accumulate step. The sample that closes
// a window adds a scaling step, WINDOW_BITS+17 restoring divider steps (33 at
// the default width) and a load of the result register. The result register
// holds a finished result while the next sample is taken; the block waits
// before loading a new result only if the previous one has not been taken
// yet. The user must write registers only while the block is idle; the block
// itself does not enforce this. Writes never clear the running sum.
module audio_db_window_average_meter
	import adwam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// sample stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [LEVEL_W-1:0]  m_tdata,   // [15:0] mean_level (signed Q8.8)
	// APB register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOG_FS = 4'd1;
	localparam logic [3:0] ST_NORM   = 4'd2;
	localparam logic [3:0] ST_LOG_M  = 4'd3;
	localparam logic [3:0] ST_DB     = 4'd4;
	localparam logic [3:0] ST_ACC    = 4'd5;
	localparam logic [3:0] ST_SCALE  = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;

	localparam int LOG_W = 5 + LOG_FRAC;

	// Configuration registers
	logic [1:0]  format_q;
	logic [15:0] length_q;
	logic [15:0] limit_q;

	// Sequencer and datapath state
	logic [3:0]             state_q;
	logic [ITER_W-1:0]      iter_q;
	logic [SAMPLE_W-1:0]    m_q;       // sample magnitude
	logic [31:0]            x_q;       // mantissa, later the log difference
	logic [4:0]             e_q;       // log2 integer part
	logic [LOG_FRAC-1:0]    r_q;       // log2 fraction bits
	logic [LOG_W-1:0]       lfs_q;     // log2 of full scale
	logic [LEVEL_W-1:0]     p_q;       // level magnitude of this sample
	logic [SUM_W-1:0]       sum_q;
	logic [WINDOW_BITS-1:0] cnt_q;
	logic [EMIT_W-1:0]      emitted_q;
	logic [QUOT_W-1:0]      num_q;     // dividend, shifted out as quotient fills in
	logic [WINDOW_BITS-1:0] rem_q;
	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     out_data_q;

	// Effective window length and limit
	logic [LEN_CMP_W-1:0]   len_ext;
	logic [WINDOW_BITS-1:0] len_eff;
	logic [EMIT_W-1:0]      lim_eff;
	logic                   stopped;

	always_comb begin
		len_ext = LEN_CMP_W'(length_q);
		if (length_q == 16'd0) begin
			len_eff = WINDOW_BITS'(1);
		end else if (len_ext > LEN_CMP_W'(CNT_MAX)) begin
			len_eff = CNT_MAX;
		end else begin
			len_eff = len_ext[WINDOW_BITS-1:0];
		end
		lim_eff = (limit_q == 16'd0) ? EMIT_W'(1) : limit_q;
		stopped = (emitted_q >= lim_eff);
	end

	// Sample magnitude and the full scale of the format, with the full scale
	// already normalized so its log needs no shift search.
	logic [SAMPLE_W-1:0] mag;
	logic [SAMPLE_W-1:0] fs;
	logic [31:0]         fs_mant;
	logic [4:0]          fs_exp;
	logic [16:0]         mag16;

	always_comb begin
		mag16 = s_tdata[15] ? (17'h10000 - {1'b0, s_tdata[15:0]}) : {1'b0, s_tdata[15:0]};
		unique case (format_q)
			FMT_U8: begin
				mag     = {24'd0, s_tdata[7:0]};
				fs      = 32'd255;
				fs_mant = 32'hFF000000;
				fs_exp  = 5'd7;
			end
			FMT_S16: begin
				mag     = {15'd0, mag16};
				fs      = 32'd32767;
				fs_mant = 32'hFFFE0000;
				fs_exp  = 5'd14;
			end
			default: begin
				// s32, and the unused code treated alike
				mag     = s_tdata[SAMPLE_W-1] ? (32'd0 - s_tdata) : s_tdata;
				fs      = 32'd2147483647;
				fs_mant = 32'hFFFFFFFE;
				fs_exp  = 5'd30;
			end
		endcase
	end

	// Shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	always_comb begin
		unique case (state_q)
			ST_LOG_FS, ST_LOG_M: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = x_q;
			end
			ST_DB: begin
				mul_a = MUL_A_W'(x_q);
				mul_b = DB_PER_LOG2;
			end
			ST_SCALE: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = INV_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	// Squaring step: truncate x*x to Q2.31, halve when 2.0 or more
	logic [32:0]         sq;
	logic [31:0]         x_sq;
	logic [LOG_FRAC-1:0] r_next;

	always_comb begin
		sq     = prod[63:31];
		x_sq   = sq[32] ? sq[32:1] : sq[31:0];
		r_next = {r_q[LOG_FRAC-2:0], sq[32]};
	end

	// Normalizing shift step
	logic [4:0]  norm_sh;
	logic        norm_zero;

	always_comb begin
		unique case (iter_q[2:0])
			3'd0:    norm_sh = 5'd16;
			3'd1:    norm_sh = 5'd8;
			3'd2:    norm_sh = 5'd4;
			3'd3:    norm_sh = 5'd2;
			default: norm_sh = 5'd1;
		endcase
		norm_zero = ((x_q >> (6'd32 - {1'b0, norm_sh})) == 32'd0);
	end

	// dB scaling with rounding and the floor
	logic [63:0]        db_round;
	logic [39:0]        db_p;
	logic [LEVEL_W-1:0] level;

	always_comb begin
		db_round = prod[63:0] + (64'd1 << 23);
		db_p     = db_round[63:24];
		level    = (db_p > 40'(LEVEL_FLOOR)) ? LEVEL_FLOOR : db_p[LEVEL_W-1:0];
	end

	// Mean scaling: floor((sum*k + len*2^19) / (len*2^20)) = floor((.. >> 20) / len)
	logic [SUM_W+20:0] scale_t;

	always_comb begin
		scale_t = (SUM_W+21)'(prod[SUM_W+19:0]) + ((SUM_W+21)'(len_eff) << 19);
	end

	// Restoring divider step
	logic [WINDOW_BITS:0] rem_sh;
	logic                 rem_ge;
	logic [WINDOW_BITS:0] rem_sub;

	always_comb begin
		rem_sh  = {rem_q, num_q[QUOT_W-1]};
		rem_ge  = (rem_sh >= {1'b0, len_eff});
		rem_sub = rem_sh - {1'b0, len_eff};
	end

	logic [WINDOW_BITS-1:0] cnt_next;
	logic                   out_free;

	assign cnt_next = cnt_q + WINDOW_BITS'(1);
	assign out_free = !out_valid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a taken result; the result load below refills it
			if (out_valid_q && m_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && !stopped) begin
						priority if (mag == 32'd0) begin
							p_q     <= LEVEL_FLOOR;
							state_q <= ST_ACC;
						end else if (mag >= fs) begin
							p_q     <= '0;
							state_q <= ST_ACC;
						end else begin
							m_q     <= mag;
							x_q     <= fs_mant;
							e_q     <= fs_exp;
							r_q     <= '0;
							iter_q  <= '0;
							state_q <= ST_LOG_FS;
						end
					end
				end
				ST_LOG_FS: begin
					r_q <= r_next;
					if (iter_q == ITER_W'(LOG_FRAC - 1)) begin
						lfs_q   <= {e_q, r_next};
						x_q     <= m_q;
						e_q     <= 5'd31;
						iter_q  <= '0;
						state_q <= ST_NORM;
					end else begin
						x_q    <= x_sq;
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				ST_NORM: begin
					if (norm_zero) begin
						x_q <= x_q << norm_sh;
						e_q <= e_q - norm_sh;
					end
					if (iter_q == ITER_W'(NORM_STEPS - 1)) begin
						r_q     <= '0;
						iter_q  <= '0;
						state_q <= ST_LOG_M;
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				ST_LOG_M: begin
					r_q <= r_next;
					if (iter_q == ITER_W'(LOG_FRAC - 1)) begin
						// log difference, wrapping as a 32-bit value
						x_q     <= 32'(lfs_q) - 32'({e_q, r_next});
						iter_q  <= '0;
						state_q <= ST_DB;
					end else begin
						x_q    <= x_sq;
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				ST_DB: begin
					p_q     <= level;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q <= sum_q + SUM_W'(p_q);
					if (cnt_next < len_eff) begin
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					num_q   <= scale_t[SUM_W+20:20];
					rem_q   <= '0;
					sum_q   <= '0;
					iter_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_ge ? rem_sub[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
					num_q  <= {num_q[QUOT_W-2:0], rem_ge};
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_W'(QUOT_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the previous result is taken
					if (out_free) begin
						out_data_q  <= LEVEL_W'(0) - num_q[LEVEL_W-1:0];
						out_valid_q <= 1'b1;
						if (emitted_q != {EMIT_W{1'b1}}) begin
							emitted_q <= emitted_q + EMIT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// APB registers
	logic cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= RST_FORMAT;
			length_q <= RST_LENGTH;
			limit_q  <= RST_LIMIT;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_FORMAT: format_q <= pwdata[1:0];
				REG_LENGTH: length_q <= pwdata[15:0];
				REG_LIMIT:  limit_q  <= pwdata[15:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FORMAT: prdata = {30'd0, format_q};
			REG_LENGTH: prdata = {16'd0, length_q};
			REG_LIMIT:  prdata = {16'd0, limit_q};
			default:    prdata = 32'd0;
		endcase
	end

	// Assertions
	a_log_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOG_FS || state_q == ST_LOG_M) |-> x_q[31])
		else $error("log mantissa not normalized");

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < len_eff))
		else $error("divider remainder not below window length");

	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && stopped) |=> (state_q == ST_IDLE))
		else $error("sample processed after window limit");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(emitted_q) |-> ($past(state_q) == ST_EMIT && m_tvalid))
		else $error("window count changed without a result");

endmodule

[tb/sv/audio_db_window_average_meter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for audio_db_window_average_meter: APB register setup,
// sample stream stimulus and a fixed-point window mean predictor checked per item.
// Depends on adwam_pkg and the block's RTL.
module audio_db_window_average_meter_tb;
	import adwam_pkg::*;

	// Quiet cycles allowed before the run is declared hung: covers one sample's
	// processing, the divider, both sides' longest idle bursts and a settle pause.
	localparam int WATCHDOG_CYCLES = 3000;
	// Cycles to let pass once nothing is expected, so a sample that causes no
	// result is surely done before the next register write.
	localparam int SETTLE_CYCLES   = 120;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_ITEMS     = 38;

	// Format code the block has no meaning for; it must behave as s32.
	localparam logic [1:0] FMT_SPARE = 2'd3;

	localparam logic [31:0] FULL_U8  = 32'd255;
	localparam logic [31:0] FULL_S16 = 32'd32767;
	localparam logic [31:0] FULL_S32 = 32'h7FFF_FFFF;
	localparam logic [63:0] DB_ROUND = 64'h80_0000;   // half of 2^24

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata;   // [31:0] sample
	logic                m_tvalid;
	logic                m_tready;
	logic [LEVEL_W-1:0]  m_tdata;   // [15:0] mean_level (signed Q8.8)
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [3:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// Shadow of the block's registers and running state
	logic [1:0]             fmt_sel;
	logic [15:0]            win_len;
	logic [15:0]            win_limit;
	logic [63:0]            drop_sum;     // sum of level magnitudes (level = -mag)
	logic [WINDOW_BITS-1:0] fill_count;
	logic [15:0]            windows_out;

	logic [LEVEL_W-1:0] mean_expected [$];
	logic [LEVEL_W-1:0] mean_want;
	int                 fail_count;
	bit                 idle_on;
	int                 quiet;

	audio_db_window_average_meter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// log2 of a nonzero magnitude as unsigned Q16: leading one gives the
	// integer part, each fraction bit comes from squaring the Q1.31 mantissa.
	function automatic logic [31:0] log2_fixed(input logic [31:0] m);
		logic [4:0]  e;
		logic [63:0] x;
		logic [15:0] r;
		e = 5'd31;
		while (e > 0 && !m[e])
			e--;
		x = 64'(m) << (5'd31 - e);
		r = '0;
		for (int i = 0; i < LOG_FRAC; i++) begin
			x = (x * x) >> 31;
			r = {r[14:0], 1'b0};
			if (x >= 64'h1_0000_0000) begin
				r[0] = 1'b1;
				x = x >> 1;
			end
		end
		return {11'd0, e, r};
	endfunction

	// Magnitude of the Q8.8 dB level of one sample in the given format
	function automatic logic [31:0] level_drop(input logic [31:0] raw, input logic [1:0] fmt);
		logic [31:0] m;
		logic [31:0] fs;
		logic [31:0] d;
		logic [63:0] p;
		case (fmt)
			FMT_U8: begin
				m  = {24'd0, raw[7:0]};
				fs = FULL_U8;
			end
			FMT_S16: begin
				m  = raw[15] ? (32'h1_0000 - {16'd0, raw[15:0]}) : {16'd0, raw[15:0]};
				fs = FULL_S16;
			end
			default: begin
				m  = raw[31] ? (32'd0 - raw) : raw;
				fs = FULL_S32;
			end
		endcase
		if (m == 0)
			return 32'(LEVEL_FLOOR);
		if (m >= fs)
			return 32'd0;
		d = log2_fixed(fs) - log2_fixed(m);
		p = (64'(d) * 64'(DB_PER_LOG2) + DB_ROUND) >> 24;
		if (p > 64'(LEVEL_FLOOR))
			p = 64'(LEVEL_FLOOR);
		return 32'(p);
	endfunction

	// Advance the shadow state by one accepted sample; queue a mean at window end
	task automatic take_sample(input logic [31:0] raw);
		logic [15:0] len;
		logic [15:0] lim;
		logic [63:0] q;
		len = (win_len == 0) ? 16'd1 : win_len;
		if (len > 16'(CNT_MAX))
			len = 16'(CNT_MAX);
		lim = (win_limit == 0) ? 16'd1 : win_limit;
		// Stopped: drop the sample and leave the state alone
		if (windows_out >= lim)
			return;
		drop_sum   = drop_sum + 64'(level_drop(raw, fmt_sel));
		fill_count = fill_count + 1'b1;
		if (fill_count < len)
			return;
		q = (drop_sum * 64'(INV_SCALE) + (64'(len) << 19)) / (64'(len) << 20);
		mean_expected.push_back(LEVEL_W'(64'd0 - q));
		drop_sum   = '0;
		fill_count = '0;
		if (windows_out != 16'hFFFF)
			windows_out++;
	endtask

	// Present one sample, with random idle bursts ahead of it, and hold it
	// until the block takes it.
	task automatic send_sample(input logic [31:0] raw);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			do
				repeat ($urandom_range(1, 17)) @(negedge clk);
			while ($urandom_range(0, 3) == 0);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do
			@(posedge clk);
		while (!s_tready);
		take_sample(raw);
	endtask

	// Drop valid, wait for every expected mean, then let a late sample finish
	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (mean_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_read(input logic [1:0] idx, output logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		value = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] got;
		reg_read(idx, got);
		if (got !== want) begin
			$error("register %0d: expected %0d, got %0d", idx, want, got);
			fail_count++;
		end
	endtask

	// Write one register, mirror it in the shadow copy and read it back
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_FORMAT: begin
				fmt_sel = value[1:0];
				kept    = {30'd0, value[1:0]};
			end
			REG_LENGTH: begin
				win_len = value[15:0];
				kept    = {16'd0, value[15:0]};
			end
			default: begin
				win_limit = value[15:0];
				kept      = {16'd0, value[15:0]};
			end
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_reg(idx, kept);
	endtask

	// Random sample shaped toward the interesting magnitudes of a format
	function automatic logic [31:0] pick_sample(input logic [1:0] fmt);
		logic [31:0] v;
		logic [31:0] fs;
		fs = (fmt == FMT_U8) ? FULL_U8 : (fmt == FMT_S16) ? FULL_S16 : FULL_S32;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = '0;
			2: v = 32'($urandom_range(1, 300));
			3: v = fs - 32'($urandom_range(0, 2)) + 32'($urandom_range(0, 2));
			4: v = $urandom >> $urandom_range(0, 31);
			default: v = {{16{1'b0}}, 16'($urandom)};
		endcase
		if ($urandom_range(0, 1) == 1)
			v = 32'd0 - v;
		return v;
	endfunction

	// Register values after reset
	task automatic test_reset_values();
		check_reg(REG_FORMAT, 32'(RST_FORMAT));
		check_reg(REG_LENGTH, 32'(RST_LENGTH));
		check_reg(REG_LIMIT, 32'(RST_LIMIT));
	endtask

	// Zero window limit acts as one: one mean comes out, then samples are dropped.
	// Must run before any window closes.
	task automatic test_zero_limit();
		reg_write(REG_LIMIT, 32'd0);
		reg_write(REG_LENGTH, 32'd1);
		send_sample(32'h0000_4000);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_8000);
		drain_block();
		reg_write(REG_LIMIT, 32'(RST_LIMIT));
	endtask

	// Longest window, cut short mid-window; then zero length acting as one
	task automatic test_short_window();
		reg_write(REG_LENGTH, 32'h0000_FFFF);
		send_sample(32'h0000_7FFF);
		send_sample(32'h0000_0001);
		send_sample(32'h0000_C000);
		drain_block();
		// Lowered below the count gathered: close on the next sample
		reg_write(REG_LENGTH, 32'd2);
		send_sample(32'h0000_0100);
		drain_block();
		reg_write(REG_LENGTH, 32'd0);
		send_sample(32'h0000_1234);
		send_sample(32'h0000_FFFF);
		drain_block();
	endtask

	// Every format code with corner samples such as silence, smallest magnitude, full scale and beyond
	task automatic test_format_corners();
		logic [31:0] corner_vals [4][5];
		corner_vals = '{
			'{32'h0000_0000, 32'h0000_0001, 32'h0000_00FE, 32'h0000_00FF, 32'hFFFF_FF80},
			'{32'h0000_0000, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF},
			'{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF},
			'{32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_8000, 32'hFFFF_0000, 32'h1234_5678}
		};
		reg_write(REG_LENGTH, 32'd1);
		for (int f = 0; f < 4; f++) begin
			reg_write(REG_FORMAT, 32'(f));
			for (int k = 0; k < 5; k++)
				send_sample(corner_vals[f][k]);
			drain_block();
		end
	endtask

	// Random phases: new format and length each phase, one phase hitting the
	// window limit mid-way, and the last phase with no idling at all.
	task automatic test_random_windows();
		logic [1:0]  fmt;
		logic [15:0] len;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				idle_on = 1'b0;
			fmt = 2'($urandom_range(0, 3));
			len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(17, 40))
			                                  : 16'($urandom_range(1, 6));
			reg_write(REG_FORMAT, {30'($urandom), fmt});
			reg_write(REG_LENGTH, {16'($urandom), len});
			if (phase == 6)
				reg_write(REG_LIMIT, 32'(windows_out + 16'd2));
			else if (phase == 7)
				reg_write(REG_LIMIT, 32'(RST_LIMIT));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(fmt));
			drain_block();
		end
	endtask

	// Result side: random ready bursts while idling is on
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each taken result with the oldest expected mean
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (mean_expected.size() == 0) begin
				$error("mean_level: expected none, got %0d", $signed(m_tdata));
				fail_count++;
			end else begin
				mean_want = mean_expected.pop_front();
				if (m_tdata !== mean_want) begin
					$error("mean_level: expected %0d, got %0d",
						$signed(mean_want), $signed(m_tdata));
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run after too long with nothing taken on any port
	initial begin
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		fail_count  = 0;
		idle_on     = 1'b1;
		fmt_sel     = RST_FORMAT;
		win_len     = RST_LENGTH;
		win_limit   = RST_LIMIT;
		drop_sum    = '0;
		fill_count  = '0;
		windows_out = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_zero_limit();
		test_short_window();
		test_format_corners();
		test_random_windows();
		drain_block();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
hw/rtl/adwam_pkg.sv
hw/rtl/audio_db_window_average_meter.sv
tb/sv/audio_db_window_average_meter_tb.sv
